/* hw/rtl/lcd_nibble_bus_number_decoder_macros.svh */
// Assertion macros for the LCD nibble bus number decoder.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef LCD_NIBBLE_BUS_NUMBER_DECODER_MACROS_SVH
`define LCD_NIBBLE_BUS_NUMBER_DECODER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define LNBD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lnbd: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define LNBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lnbd: next-cycle check failed");

`endif

/* hw/rtl/lnbd_pkg.sv */
// Shared types and constants for the LCD nibble bus number decoder.
// No dependencies.
package lnbd_pkg;

   localparam int MAX_CHARS_DEFAULT = 32;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int MANT_WIDTH      = 60;
   localparam int COUNT_WIDTH     = 6;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_COMMAND = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_COMMAND  = 2'd1;

   localparam logic [7:0] SYNC_COMMAND_RESET = 8'd128;
   localparam logic [7:0] END_COMMAND_RESET  = 8'd192;

   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // Largest mantissa, and the largest accumulator that still takes one more digit.
   localparam logic [MANT_WIDTH-1:0] MANT_MAX   = 60'd999999999999999999;
   localparam logic [MANT_WIDTH-1:0] MANT_LIMIT = 60'd99999999999999999;

   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef enum logic [1:0] {
      PHASE_SYNC_HI = 2'd0,
      PHASE_SYNC_LO = 2'd1,
      PHASE_BYTE_HI = 2'd2,
      PHASE_BYTE_LO = 2'd3
   } phase_type;

endpackage

/* hw/rtl/lcd_nibble_bus_number_decoder.sv */
// Top level of the LCD nibble bus number decoder: sync hunt, byte assembly, decimal parse.
// Depends on lnbd_pkg and lcd_nibble_bus_number_decoder_macros.svh.
`include "lcd_nibble_bus_number_decoder_macros.svh"

// Sniffs a 4-bit character-LCD bus. Each req word is one enable strobe with DB4..DB7 in
// req_nibble, high nibble first. The block hunts for the sync command byte (csr index 0),
// then pairs nibbles into bytes. A byte equal to the end command (csr index 1) closes the
// frame and yields one rsp word of kind 1 with the parsed number; any other byte yields a
// rsp word of kind 0 with the character and the running parse state. Digits accumulate into
// a 60-bit mantissa, the first dot starts the fraction, other characters are ignored.
// Characters past MAX_CHARS and mantissas past 999999999999999999 set the overflow flag and
// saturate. Rate: one nibble per clock; the rsp word appears in the cycle after the low
// nibble of a byte is accepted. The rate is set by the combinational parse step, whose
// longest path is the times-ten shift-add on the 60-bit accumulator. While a rsp word waits
// on rsp_ready, nibbles that produce no word (sync and high nibbles) are still taken.
// Configuration is written through csr_we/csr_index/csr_wdata while the bus is idle.
module lcd_nibble_bus_number_decoder #(
   parameter int MAX_CHARS = lnbd_pkg::MAX_CHARS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // nibble input
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [3:0]                            req_nibble,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_kind,
   output logic [7:0]                            rsp_char_code,
   output logic [lnbd_pkg::MANT_WIDTH-1:0]       rsp_mantissa,
   output logic [lnbd_pkg::COUNT_WIDTH-1:0]      rsp_fraction_digits,
   output logic [lnbd_pkg::COUNT_WIDTH-1:0]      rsp_char_total,
   output logic                                  rsp_overflow_flag,
   // configuration writes
   input  logic                                  csr_we,
   input  logic [lnbd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lnbd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam logic [lnbd_pkg::COUNT_WIDTH-1:0] CHAR_LIMIT = lnbd_pkg::COUNT_WIDTH'(MAX_CHARS);

   // configuration registers
   logic [7:0] sync_cmd_ff, sync_cmd_in;
   logic [7:0] end_cmd_ff, end_cmd_in;

   // bus tracking and parse state
   lnbd_pkg::phase_type                 phase_ff, phase_in;
   logic [3:0]                          upper_ff, upper_in;
   logic                                in_frac_ff, in_frac_in;
   logic [lnbd_pkg::MANT_WIDTH-1:0]     acc_ff, acc_in;
   logic [lnbd_pkg::COUNT_WIDTH-1:0]    frac_cnt_ff, frac_cnt_in;
   logic [lnbd_pkg::COUNT_WIDTH-1:0]    char_cnt_ff, char_cnt_in;
   logic                                ovf_ff, ovf_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff, rsp_kind_in;
   logic [7:0]                          rsp_code_ff, rsp_code_in;
   logic [lnbd_pkg::MANT_WIDTH-1:0]     rsp_mant_ff, rsp_mant_in;
   logic [lnbd_pkg::COUNT_WIDTH-1:0]    rsp_frac_ff, rsp_frac_in;
   logic [lnbd_pkg::COUNT_WIDTH-1:0]    rsp_total_ff, rsp_total_in;
   logic                                rsp_ovf_ff, rsp_ovf_in;

   logic       req_fire;
   logic [7:0] byte_val;
   logic       byte_is_end;
   logic       byte_lo_fire;
   logic       parse_idle;

   assign byte_val    = {upper_ff, req_nibble};
   assign byte_is_end = (byte_val == end_cmd_ff);

   // Only a low byte nibble produces a word, so only that one waits on the result register.
   assign req_ready = !rsp_valid_ff || rsp_ready || (phase_ff != lnbd_pkg::PHASE_BYTE_LO);
   assign req_fire  = req_valid && req_ready;

   assign byte_lo_fire = req_fire && (phase_ff == lnbd_pkg::PHASE_BYTE_LO);
   assign parse_idle   = (char_cnt_ff == '0) && (acc_ff == '0) && (frac_cnt_ff == '0) &&
                         !ovf_ff && !in_frac_ff;

   // Configuration writes; unknown indexes drop the write.
   always_comb begin
      sync_cmd_in = sync_cmd_ff;
      end_cmd_in  = end_cmd_ff;
      if (csr_we) begin
         unique case (csr_index)
            lnbd_pkg::CSR_SYNC_COMMAND: sync_cmd_in = csr_wdata;
            lnbd_pkg::CSR_END_COMMAND:  end_cmd_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Next phase: hunt for sync, then alternate high and low byte nibbles.
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (phase_ff)
            lnbd_pkg::PHASE_SYNC_HI:
               phase_in = (req_nibble == sync_cmd_ff[7:4]) ? lnbd_pkg::PHASE_SYNC_LO
                                                           : lnbd_pkg::PHASE_SYNC_HI;
            lnbd_pkg::PHASE_SYNC_LO:
               phase_in = (byte_val == sync_cmd_ff) ? lnbd_pkg::PHASE_BYTE_HI
                                                    : lnbd_pkg::PHASE_SYNC_HI;
            lnbd_pkg::PHASE_BYTE_HI:
               phase_in = lnbd_pkg::PHASE_BYTE_LO;
            lnbd_pkg::PHASE_BYTE_LO:
               phase_in = byte_is_end ? lnbd_pkg::PHASE_SYNC_HI : lnbd_pkg::PHASE_BYTE_HI;
            default:
               phase_in = lnbd_pkg::PHASE_SYNC_HI;
         endcase
      end
   end

   // Parse step and result load.
   always_comb begin
      logic                            is_digit;
      logic [lnbd_pkg::MANT_WIDTH-1:0] acc_times_ten;
      logic                            hi_phase;

      is_digit      = (byte_val >= lnbd_pkg::CHAR_ZERO) && (byte_val <= lnbd_pkg::CHAR_NINE);
      // times ten as shift-add, plus the digit (low nibble of an ASCII digit)
      acc_times_ten = {acc_ff[lnbd_pkg::MANT_WIDTH-4:0], 3'b000}
                    + {acc_ff[lnbd_pkg::MANT_WIDTH-2:0], 1'b0}
                    + lnbd_pkg::MANT_WIDTH'(req_nibble);
      hi_phase      = (phase_ff == lnbd_pkg::PHASE_SYNC_HI) ||
                      (phase_ff == lnbd_pkg::PHASE_BYTE_HI);

      upper_in     = upper_ff;
      in_frac_in   = in_frac_ff;
      acc_in       = acc_ff;
      frac_cnt_in  = frac_cnt_ff;
      char_cnt_in  = char_cnt_ff;
      ovf_in       = ovf_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_mant_in  = rsp_mant_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_total_in = rsp_total_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (req_fire && hi_phase) begin
         upper_in = req_nibble;
      end

      if (req_fire && (phase_ff == lnbd_pkg::PHASE_BYTE_LO)) begin
         rsp_valid_in = 1'b1;
         if (byte_is_end) begin
            // report the finished frame, then clear the parse state
            rsp_kind_in  = lnbd_pkg::KIND_FRAME;
            rsp_code_in  = 8'd0;
            rsp_mant_in  = acc_ff;
            rsp_frac_in  = frac_cnt_ff;
            rsp_total_in = char_cnt_ff;
            rsp_ovf_in   = ovf_ff;
            in_frac_in   = 1'b0;
            acc_in       = '0;
            frac_cnt_in  = '0;
            char_cnt_in  = '0;
            ovf_in       = 1'b0;
         end else begin
            if (char_cnt_ff >= CHAR_LIMIT) begin
               // past the limit: emit but do not count or parse
               ovf_in = 1'b1;
            end else begin
               char_cnt_in = char_cnt_ff + lnbd_pkg::COUNT_WIDTH'(1);
               if (byte_val == lnbd_pkg::CHAR_DOT) begin
                  in_frac_in = 1'b1;
               end else if (is_digit) begin
                  if (acc_ff > lnbd_pkg::MANT_LIMIT) begin
                     // saturate in the integer part, drop the digit in the fraction
                     ovf_in = 1'b1;
                     if (!in_frac_ff) begin
                        acc_in = lnbd_pkg::MANT_MAX;
                     end
                  end else begin
                     acc_in = acc_times_ten;
                     if (in_frac_ff) begin
                        frac_cnt_in = frac_cnt_ff + lnbd_pkg::COUNT_WIDTH'(1);
                     end
                  end
               end
            end
            rsp_kind_in  = lnbd_pkg::KIND_CHAR;
            rsp_code_in  = byte_val;
            rsp_mant_in  = acc_in;
            rsp_frac_in  = frac_cnt_in;
            rsp_total_in = char_cnt_in;
            rsp_ovf_in   = ovf_in;
         end
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_cmd_ff  <= lnbd_pkg::SYNC_COMMAND_RESET;
         end_cmd_ff   <= lnbd_pkg::END_COMMAND_RESET;
         phase_ff     <= lnbd_pkg::PHASE_SYNC_HI;
         upper_ff     <= 4'd0;
         in_frac_ff   <= 1'b0;
         acc_ff       <= '0;
         frac_cnt_ff  <= '0;
         char_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sync_cmd_ff  <= sync_cmd_in;
         end_cmd_ff   <= end_cmd_in;
         phase_ff     <= phase_in;
         upper_ff     <= upper_in;
         in_frac_ff   <= in_frac_in;
         acc_ff       <= acc_in;
         frac_cnt_ff  <= frac_cnt_in;
         char_cnt_ff  <= char_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_mant_ff  <= rsp_mant_in;
      rsp_frac_ff  <= rsp_frac_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_char_code       = rsp_code_ff;
   assign rsp_mantissa        = rsp_mant_ff;
   assign rsp_fraction_digits = rsp_frac_ff;
   assign rsp_char_total      = rsp_total_ff;
   assign rsp_overflow_flag   = rsp_ovf_ff;

   // A closed frame leaves no parse state behind.
   `LNBD_ASSERT_NEXT(a_frame_clears, byte_lo_fire && byte_is_end, parse_idle)
   // The character count never passes the limit.
   `LNBD_ASSERT_NOW(a_count_bound, rsp_valid_ff, rsp_total_ff <= CHAR_LIMIT)
   // The mantissa never exceeds its saturation bound.
   `LNBD_ASSERT_NOW(a_mant_bound, 1'b1, acc_ff <= lnbd_pkg::MANT_MAX)
   // A waiting result is never overwritten by a low byte nibble.
   `LNBD_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && !rsp_ready, !byte_lo_fire)

endmodule
